>>> rtl/core/cnpc_pkg.sv
// cnpc_pkg: shared types and constants for the cached nearest palette color block
// holds the command codes and the request/result payload structs
// no dependencies
package cnpc_pkg;

	localparam int COLOR_BITS = 6;
	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW = 8;
	localparam int DIST_W = 2 * COLOR_BITS + 2;

	localparam int CACHE_ENTRIES_DEF = 32;
	localparam int SEARCHED_ENTRIES_DEF = 255;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef logic [COLOR_BITS-1:0] comp_t;

	typedef struct packed {
		comp_t red;
		comp_t green;
		comp_t blue;
	} triple_t;

	typedef struct packed {
		cmd_t              command;
		logic [PAL_AW-1:0] entry_index;
		comp_t             red;
		comp_t             green;
		comp_t             blue;
	} req_t;

	typedef struct packed {
		logic [PAL_AW-1:0] color_index;
		logic              cache_hit;
	} rsp_t;

	typedef struct packed {
		triple_t           color;
		logic [PAL_AW-1:0] answer;
	} cent_t;

endpackage

>>> rtl/core/cached_nearest_palette_color.sv
// cached_nearest_palette_color: nearest palette entry search behind a recent-color cache
// one shared distance unit walks the palette memory; the cache memory is scanned first
// depends on cnpc_pkg
//
// channel   direction  ports                   transaction
// request   in         start, busy, request    start high while busy low
// result    out        done, result            one cycle with done high
//
// write, flush and unused commands: result in the cycle after acceptance
// lookup hit at slot p: result from the scan; p>0 then swaps in S_SWAP_LO, S_SWAP_HI
// lookup miss: scan of the filled cache entries (none when empty), then up to
//   SEARCHED_ENTRIES entries through the single palette read port, one entry a cycle
// reset empties the cache; the palette holds nothing defined until written
// the receiver cannot stall; busy stays high until the cache update is written
module cached_nearest_palette_color
	import cnpc_pkg::*;
#(
	parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
	parameter int SEARCHED_ENTRIES = SEARCHED_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int FW = $clog2(CACHE_ENTRIES + 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(CACHE_ENTRIES);
	localparam logic [CIW-1:0] LAST_SLOT = CIW'(CACHE_ENTRIES - 1);
	localparam logic [PAL_AW-1:0] LAST_SEARCHED = PAL_AW'(SEARCHED_ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CSCAN,
		S_PSEARCH,
		S_SWAP_LO,
		S_SWAP_HI
	} state_t;

	function automatic logic [DIST_W-1:0] sq_dist(triple_t a, triple_t b);
		comp_t dr, dg, db;
		logic [2*COLOR_BITS-1:0] sr, sg, sb;
		dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
		dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
		db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
		sr = dr * dr;
		sg = dg * dg;
		sb = db * db;
		return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
	endfunction

	state_t state_q;
	triple_t trip_q;
	logic [CIW-1:0] ci_q;
	cent_t prev_q;
	logic [PAL_AW-1:0] pi_q;
	logic [DIST_W-1:0] best_d_q;
	logic [PAL_AW-1:0] best_i_q;
	logic [FW-1:0] fill_q;
	logic done_q;
	rsp_t result_q;

	cent_t cache_mem [CACHE_ENTRIES];
	cent_t cache_rd_q;
	triple_t pal_mem [PAL_DEPTH];
	triple_t pal_rd_q;

	logic accept;
	triple_t req_trip;
	logic c_match, c_last;
	logic [DIST_W-1:0] sq_d;
	logic p_better, p_fin;
	logic [PAL_AW-1:0] p_idx;
	logic [CIW-1:0] slot;
	logic [CIW-1:0] cache_raddr, cache_waddr;
	logic cache_we;
	cent_t cache_wdata;
	logic [PAL_AW-1:0] pal_raddr;
	logic pal_we;

	assign accept = start && (state_q == S_IDLE);
	assign req_trip = '{red: request.red, green: request.green, blue: request.blue};

	assign c_match = (cache_rd_q.color == trip_q);
	assign c_last = (FW'(ci_q) == (fill_q - 1'b1));

	// the shared distance unit sees one palette entry a cycle
	assign sq_d = sq_dist(trip_q, pal_rd_q);
	assign p_better = (best_d_q > sq_d);
	assign p_fin = (p_better && (sq_d == '0)) || (pi_q == LAST_SEARCHED);
	assign p_idx = p_better ? pi_q : best_i_q;
	assign slot = (fill_q < FILL_FULL) ? CIW'(fill_q) : LAST_SLOT;

	assign pal_raddr = (state_q == S_PSEARCH) ? pi_q + 1'b1 : '0;
	assign pal_we = accept && (request.command == CMD_WRITE);

	always_comb begin
		cache_raddr = (state_q == S_CSCAN) ? ci_q + 1'b1 : '0;
		cache_we = 1'b0;
		cache_waddr = slot;
		cache_wdata = '{color: trip_q, answer: p_idx};
		unique case (state_q)
			S_PSEARCH: begin
				cache_we = p_fin;
			end
			S_SWAP_LO: begin
				cache_we = 1'b1;
				cache_waddr = ci_q - 1'b1;
				cache_wdata = '{color: trip_q, answer: result_q.color_index};
			end
			S_SWAP_HI: begin
				cache_we = 1'b1;
				cache_waddr = ci_q;
				cache_wdata = prev_q;
			end
			default: begin
				cache_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cache_we) begin
			cache_mem[cache_waddr] <= cache_wdata;
		end
		cache_rd_q <= cache_mem[cache_raddr];
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[request.entry_index] <= req_trip;
		end
		pal_rd_q <= pal_mem[pal_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trip_q <= req_trip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			done_q <= 1'b0;
			result_q <= '0;
			ci_q <= '0;
			prev_q <= '0;
			pi_q <= '0;
			best_d_q <= '1;
			best_i_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					ci_q <= '0;
					pi_q <= '0;
					best_d_q <= '1;
					best_i_q <= '0;
					if (accept) begin
						case (request.command) inside
							CMD_LOOKUP: begin
								state_q <= (fill_q == '0) ? S_PSEARCH : S_CSCAN;
							end
							CMD_WRITE, CMD_FLUSH: begin
								fill_q <= '0;
								done_q <= 1'b1;
								result_q <= '0;
							end
							default: begin
								done_q <= 1'b1;
								result_q <= '0;
							end
						endcase
					end
				end
				S_CSCAN: begin
					if (c_match) begin
						done_q <= 1'b1;
						result_q <= '{color_index: cache_rd_q.answer, cache_hit: 1'b1};
						state_q <= (ci_q == '0) ? S_IDLE : S_SWAP_LO;
					end else begin
						prev_q <= cache_rd_q;
						if (c_last) begin
							state_q <= S_PSEARCH;
						end else begin
							ci_q <= ci_q + 1'b1;
						end
					end
				end
				S_PSEARCH: begin
					if (p_better) begin
						best_d_q <= sq_d;
						best_i_q <= pi_q;
					end
					pi_q <= pi_q + 1'b1;
					if (p_fin) begin
						done_q <= 1'b1;
						result_q <= '{color_index: p_idx, cache_hit: 1'b0};
						if (fill_q < FILL_FULL) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_SWAP_LO: begin
					state_q <= S_SWAP_HI;
				end
				S_SWAP_HI: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = result_q;

endmodule

>>> rtl/core/cnpc_checker.sv
// cnpc_checker: port-level checks on the cached nearest palette color block
// bound to the top level below; depends on cnpc_pkg
module cnpc_checker
	import cnpc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t request,
	input logic done,
	input rsp_t result
);

	// the transparent entry is never an answer
	a_no_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.color_index != 8'd255))
		else $error("transparent entry returned");

	// non-lookup transactions answer at once with an empty result
	a_other_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.command != CMD_LOOKUP)) |=>
			(done && !busy && (result.color_index == '0) && !result.cache_hit))
		else $error("non-lookup result wrong");

	// a lookup always makes the block busy once accepted
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.command == CMD_LOOKUP)) |=> busy)
		else $error("lookup not held busy");

	// no result without a transaction in progress or just accepted
	a_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("stray result");

endmodule

bind cached_nearest_palette_color cnpc_checker u_cnpc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.request(request),
	.done(done),
	.result(result)
);

>>> tb/sv/cached_nearest_palette_color_checker.sv
`timescale 1ns / 100ps
// checker for cached_nearest_palette_color: watches the request and result channels
// keeps its own palette and recent-color cache, predicts each result and compares it
// depends on cnpc_pkg
module cached_nearest_palette_color_checker
	import cnpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t request,
	input  logic done,
	input  rsp_t result,
	output int   errors,
	output int   in_flight
);

	localparam int CACHE_SLOTS = CACHE_ENTRIES_DEF;
	localparam int SEARCH_DEPTH = SEARCHED_ENTRIES_DEF;

	triple_t           pal_model [PAL_DEPTH];
	triple_t           cache_color [CACHE_SLOTS];
	logic [PAL_AW-1:0] cache_index [CACHE_SLOTS];
	int                cache_used = 0;
	rsp_t              expected_q [$];
	int                mismatch_count = 0;
	int                pending = 0;

	assign errors = mismatch_count;
	assign in_flight = pending;

	task automatic flag_error(string msg);
		$display("ERROR %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// lowest index wins on equal distance, exact match stops the walk
	function automatic logic [PAL_AW-1:0] nearest_entry(triple_t q);
		int best_dist;
		int d_sq;
		int dr;
		int dg;
		int db;
		int i;
		logic [PAL_AW-1:0] best_idx;
		best_dist = 32'h7fffffff;
		best_idx = '0;
		for (i = 0; i < SEARCH_DEPTH; i++) begin
			dr = int'(q.red) - int'(pal_model[i].red);
			dg = int'(q.green) - int'(pal_model[i].green);
			db = int'(q.blue) - int'(pal_model[i].blue);
			d_sq = dr * dr + dg * dg + db * db;
			if (d_sq < best_dist) begin
				best_idx = PAL_AW'(i);
				if (d_sq == 0)
					break;
				best_dist = d_sq;
			end
		end
		return best_idx;
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t              rsp;
		triple_t           q;
		triple_t           tmp_color;
		logic [PAL_AW-1:0] tmp_index;
		int                pos;
		int                slot;
		int                i;
		rsp = '0;
		q = {r.red, r.green, r.blue};
		pos = -1;
		case (r.command)
			CMD_LOOKUP: begin
				for (i = 0; i < cache_used; i++) begin
					if (cache_color[i] == q) begin
						pos = i;
						break;
					end
				end
				if (pos >= 0) begin
					rsp.color_index = cache_index[pos];
					rsp.cache_hit = 1'b1;
					// hit entry moves one place toward the front
					if (pos > 0) begin
						tmp_color = cache_color[pos - 1];
						tmp_index = cache_index[pos - 1];
						cache_color[pos - 1] = cache_color[pos];
						cache_index[pos - 1] = cache_index[pos];
						cache_color[pos] = tmp_color;
						cache_index[pos] = tmp_index;
					end
				end else begin
					if (cache_used < CACHE_SLOTS) begin
						slot = cache_used;
						cache_used++;
					end else begin
						slot = CACHE_SLOTS - 1;
					end
					rsp.color_index = nearest_entry(q);
					cache_color[slot] = q;
					cache_index[slot] = rsp.color_index;
				end
			end
			CMD_WRITE: begin
				pal_model[r.entry_index] = q;
				cache_used = 0;
			end
			CMD_FLUSH: begin
				cache_used = 0;
			end
			default: begin
			end
		endcase
		return rsp;
	endfunction

	always @(posedge clk) begin : watch
		rsp_t want;
		int   accepted;
		int   retired;
		accepted = 0;
		retired = 0;
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0) begin
					flag_error($sformatf("unexpected result index %0d hit %0b",
						result.color_index, result.cache_hit));
				end else begin
					want = expected_q.pop_front();
					retired = 1;
					if (result.color_index !== want.color_index)
						flag_error($sformatf("color_index got %0d want %0d",
							result.color_index, want.color_index));
					if (result.cache_hit !== want.cache_hit)
						flag_error($sformatf("cache_hit got %0b want %0b",
							result.cache_hit, want.cache_hit));
				end
			end
			if (start && !busy) begin
				expected_q.push_back(predict_response(request));
				accepted = 1;
			end
			pending <= pending + accepted - retired;
		end
	end

endmodule

>>> tb/sv/cached_nearest_palette_color_test.sv
`timescale 1ns / 100ps
// top of the cached_nearest_palette_color testbench: clock, reset, command stimulus, verdict
// depends on cnpc_pkg, cached_nearest_palette_color and cached_nearest_palette_color_checker
module cached_nearest_palette_color_test;

	import cnpc_pkg::*;

	localparam int CYCLE_LIMIT = 2_500_000;
	localparam int RANDOM_ITEMS = 1050;
	localparam int POOL_MAX = 48;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	req_t    request;
	logic    done;
	rsp_t    result;
	int      mismatches;
	int      in_flight;
	int      cycle_count = 0;
	int      items_sent = 0;
	bit      idle_on = 1'b1;
	triple_t pal_shadow [PAL_DEPTH];
	triple_t pool [POOL_MAX];

	cached_nearest_palette_color u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	cached_nearest_palette_color_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.errors(mismatches),
		.in_flight(in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL cached_nearest_palette_color");
			$finish;
		end
	end

	function automatic triple_t rand_triple();
		return triple_t'($urandom_range(0, (1 << (3 * COLOR_BITS)) - 1));
	endfunction

	function automatic req_t make_req(cmd_t c, logic [PAL_AW-1:0] idx, triple_t t);
		req_t r;
		r.command = c;
		r.entry_index = idx;
		{r.red, r.green, r.blue} = t;
		return r;
	endfunction

	// returns after the edge at which the transaction was taken, once busy is low
	task automatic send_item(req_t r);
		while (idle_on && $urandom_range(0, 99) < 24) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		if (r.command == CMD_WRITE)
			pal_shadow[r.entry_index] = {r.red, r.green, r.blue};
		items_sent++;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int      i;
		int      pool_size;
		int      burst_len;
		int      roll;
		int      random_end;
		triple_t t;
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole palette so no search reads an unwritten entry
		for (i = 0; i < PAL_DEPTH; i++) begin
			if (i == 0)
				t = '0;
			else if (i == PAL_DEPTH - 2)
				t = '1;
			else
				t = rand_triple();
			send_item(make_req(CMD_WRITE, PAL_AW'(i), t));
		end

		// directed: extremes, cache hit at front and behind, swap, ties, entry 255
		send_item(make_req(CMD_LOOKUP, 8'd255, '0));
		send_item(make_req(CMD_LOOKUP, 8'd0, '0));
		send_item(make_req(CMD_LOOKUP, 8'd0, '1));
		send_item(make_req(CMD_LOOKUP, 8'd0, '1));
		send_item(make_req(CMD_LOOKUP, 8'd0, '0));
		send_item(make_req(CMD_LOOKUP, 8'd0, pal_shadow[PAL_DEPTH - 1]));
		send_item(make_req(CMD_WRITE, 8'd7, {6'd20, 6'd40, 6'd60}));
		send_item(make_req(CMD_WRITE, 8'd9, {6'd20, 6'd40, 6'd60}));
		send_item(make_req(CMD_LOOKUP, 8'd0, {6'd20, 6'd40, 6'd60}));
		send_item(make_req(CMD_WRITE, 8'd3, {6'd11, 6'd30, 6'd30}));
		send_item(make_req(CMD_WRITE, 8'd5, {6'd9, 6'd30, 6'd30}));
		send_item(make_req(CMD_LOOKUP, 8'd0, {6'd10, 6'd30, 6'd30}));
		send_item(make_req(CMD_LOOKUP, 8'd0, {6'd10, 6'd30, 6'd30}));
		send_item(make_req(CMD_FLUSH, 8'd0, '0));
		send_item(make_req(CMD_LOOKUP, 8'd0, {6'd10, 6'd30, 6'd30}));
		send_item(make_req(cmd_t'(CMD_UNUSED), 8'd255, '1));
		send_item(make_req(CMD_LOOKUP, 8'd0, {6'd10, 6'd30, 6'd30}));
		// transparent entry holds the exact query but must never be chosen
		send_item(make_req(CMD_WRITE, 8'd255, {6'd63, 6'd0, 6'd63}));
		send_item(make_req(CMD_LOOKUP, 8'd255, {6'd63, 6'd0, 6'd63}));
		send_item(make_req(CMD_WRITE, 8'd0, '0));
		send_item(make_req(CMD_LOOKUP, 8'd128, {6'd0, 6'd63, 6'd0}));
		send_item(make_req(CMD_FLUSH, 8'd255, '1));

		// random bursts of mostly lookups over a small pool so the cache fills, hits and swaps
		random_end = items_sent + RANDOM_ITEMS;
		while (items_sent < random_end) begin
			pool_size = $urandom_range(1, POOL_MAX);
			for (i = 0; i < pool_size; i++) begin
				if ($urandom_range(0, 2) == 0)
					pool[i] = pal_shadow[$urandom_range(0, PAL_DEPTH - 1)];
				else
					pool[i] = rand_triple();
			end
			burst_len = $urandom_range(10, 90);
			for (i = 0; i < burst_len; i++) begin
				idle_on = !(items_sent >= 700 && items_sent < 1000);
				roll = $urandom_range(0, 99);
				if (roll < 80)
					send_item(make_req(CMD_LOOKUP, PAL_AW'($urandom),
						pool[$urandom_range(0, pool_size - 1)]));
				else if (roll < 92)
					send_item(make_req(CMD_LOOKUP, PAL_AW'($urandom), rand_triple()));
				else if (roll < 95)
					send_item(make_req(CMD_WRITE, PAL_AW'($urandom), rand_triple()));
				else if (roll < 98)
					send_item(make_req(CMD_FLUSH, PAL_AW'($urandom), rand_triple()));
				else
					send_item(make_req(cmd_t'(CMD_UNUSED), PAL_AW'($urandom),
						rand_triple()));
			end
			roll = $urandom_range(0, 99);
			if (roll < 50)
				send_item(make_req(CMD_WRITE, PAL_AW'($urandom), rand_triple()));
			else if (roll < 85)
				send_item(make_req(CMD_FLUSH, PAL_AW'($urandom), rand_triple()));
			else
				send_item(make_req(cmd_t'(CMD_UNUSED), PAL_AW'($urandom), rand_triple()));
		end
		start <= 1'b0;

		// the count seen here is registered in the checker, so let it update before waiting on it
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("PASS cached_nearest_palette_color");
		else
			$display("FAIL cached_nearest_palette_color");
		$finish;
	end

endmodule
